// ----- hw/rtl/dlpm_pkg.sv -----
package dlpm_pkg;

   localparam int SAMPLE_W        = 24;
   localparam int FRAC_B          = SAMPLE_W - 1;
   localparam int DELAY_DEPTH_DEF = 4096;
   localparam int BASE_OFFSET_DEF = 1024;
   localparam int GATE_LSB        = (1 << FRAC_B) / 1000000;

   // shift-add multiplier: signed A, unsigned B taken one bit per cycle
   localparam int MUL_A_W   = 30;
   localparam int MUL_B_W   = 26;
   localparam int MUL_H_W   = 32;
   localparam int MUL_P_W   = MUL_H_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam int MOD_W       = 29;
   localparam int WET_W       = 30;
   localparam int IP_W        = 19;
   localparam int GOAL_W      = 18;
   localparam int DEPTH_SHIFT = 22;
   localparam int DEPTH_W     = GOAL_W + DEPTH_SHIFT;
   localparam int STEP_W      = DEPTH_W + 1;
   localparam int DIV_CNT_W   = $clog2(DEPTH_W);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CARRIER_GAIN   = 3'd0,
      CSR_MODULATOR_GAIN = 3'd1,
      CSR_WET_AMOUNT     = 3'd2,
      CSR_DEPTH_TARGET   = 3'd3,
      CSR_MODE_SELECT    = 3'd4,
      CSR_RAMP_STEPS     = 3'd5
   } csr_index_type;

   // round(v / 2^s), halves away from zero
   function automatic logic signed [MUL_P_W-1:0] round_shift(
      input logic signed [MUL_P_W-1:0] v,
      input int                        s);
      logic signed [MUL_P_W:0] half;
      logic signed [MUL_P_W:0] t;
      half = '0;
      half[s-1] = 1'b1;
      t = {v[MUL_P_W-1], v} + half;
      if (v[MUL_P_W-1]) begin
         t = t - $signed({{MUL_P_W{1'b0}}, 1'b1});
      end
      t = t >>> s;
      return t[MUL_P_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] saturate(
      input logic signed [MUL_P_W-1:0] v);
      logic signed [MUL_P_W-1:0] hi_lim;
      logic signed [MUL_P_W-1:0] lo_lim;
      hi_lim = $signed({{(MUL_P_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}});
      lo_lim = $signed({{(MUL_P_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}});
      if (v > hi_lim) begin
         return hi_lim[SAMPLE_W-1:0];
      end
      if (v < lo_lim) begin
         return lo_lim[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/delay_line_phase_mod_ring_mod_mixer_core.sv -----
// Each sample runs the ramp check, the depth advance and four passes through the
//   bit-serial multiplier in ring mode, or five in phase mode with a wrap step per wrap
//   of the read position and the delay-line reads; a new depth target with a nonzero
//   ramp length adds a ramp division first. One sample is in flight at a time: a new one
//   is taken only after the last has gone to the output, and a stalled output holds the last pass.
// Reset (synchronous, active high) loads register defaults and clears depth state; the
//   delay line needs no clearing pass: a fill mark makes unwritten entries read as zero.
module delay_line_phase_mod_ring_mod_mixer_core #(
   parameter int DELAY_DEPTH = dlpm_pkg::DELAY_DEPTH_DEF,
   parameter int BASE_OFFSET = dlpm_pkg::BASE_OFFSET_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [dlpm_pkg::SAMPLE_W-1:0]    req_carrier_sample,
   input  logic signed [dlpm_pkg::SAMPLE_W-1:0]    req_modulator_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dlpm_pkg::SAMPLE_W-1:0]    rsp_mixed_sample,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dlpm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dlpm_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import dlpm_pkg::*;

   localparam int AW = $clog2(DELAY_DEPTH);

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_RAMP  = 16'h0002,
      ST_DIV   = 16'h0004,
      ST_QUOT  = 16'h0008,
      ST_ADV   = 16'h0010,
      ST_MUL_C = 16'h0020,
      ST_WR    = 16'h0040,
      ST_MUL_M = 16'h0080,
      ST_MUL_O = 16'h0100,
      ST_WRAP  = 16'h0200,
      ST_RD_A  = 16'h0400,
      ST_RD_B  = 16'h0800,
      ST_RD_W  = 16'h1000,
      ST_MUL_I = 16'h2000,
      ST_MUL_R = 16'h4000,
      ST_MUL_X = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]         carrier_gain_ff, modulator_gain_ff, ramp_steps_ff;
   logic [16:0]         wet_amount_ff;
   logic [GOAL_W-1:0]   depth_target_ff;
   logic                mode_select_ff;

   logic [GOAL_W-1:0]         depth_goal_ff;
   logic [DEPTH_W-1:0]        depth_current_ff;
   logic signed [STEP_W-1:0]  depth_step_ff;
   logic [15:0]               ramp_remaining_ff;
   logic [DEPTH_W-1:0]        dvd_ff;
   logic [15:0]               rem_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;
   logic                      div_neg_ff;

   logic signed [SAMPLE_W-1:0] cin_ff, min_ff, carrier_ff, sa_ff, sb_ff;
   logic signed [MOD_W-1:0]    mod_ff;
   logic signed [WET_W-1:0]    wet_ff;
   logic signed [IP_W-1:0]     ip_ff;
   logic [15:0]                frac_ff;
   logic [AW-1:0]              wi_ff;
   logic                       full_ff;
   logic                       rvalid_ff;
   logic                       issued_ff;
   logic                       mix_done_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic                       mul_start, mul_done, in_mul;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic signed [MUL_P_W-1:0]  mul_p;

   logic                       ram_we;
   logic [AW-1:0]              ram_raddr;
   logic [SAMPLE_W-1:0]        ram_rdata;

   logic [16:0]                w_eff;
   logic signed [DEPTH_W+1:0]  num;
   logic [DEPTH_W+1:0]         num_mag;
   logic [16:0]                div_trial, div_diff;
   logic                       div_ge;
   logic [STEP_W-1:0]          quot;
   logic [STEP_W-1:0]          adv_sum;
   logic [AW-1:0]              ia, ib;
   logic [SAMPLE_W-1:0]        carrier_mag;
   logic                       gate;
   logic signed [MUL_A_W-1:0]  mod_ext;
   logic signed [MUL_P_W-1:0]  off, interp_sum, mix_sum;
   logic signed [IP_W-1:0]     ip_new;
   logic                       out_free, rsp_go, ramp_start, ramp_now;

   // ------------------------------------------------------------ datapath helpers
   always_comb begin
      w_eff       = (wet_amount_ff > 17'd65536) ? 17'd65536 : wet_amount_ff;
      num         = $signed({2'b00, depth_target_ff, {DEPTH_SHIFT{1'b0}}})
                    - $signed({2'b00, depth_current_ff});
      num_mag     = num[DEPTH_W+1] ? -num : num;
      div_trial   = {rem_ff, dvd_ff[DEPTH_W-1]};
      div_ge      = div_trial >= {1'b0, ramp_steps_ff};
      div_diff    = div_trial - {1'b0, ramp_steps_ff};
      quot        = {1'b0, dvd_ff};
      adv_sum     = $signed({1'b0, depth_current_ff}) + depth_step_ff;
      ia          = ip_ff[AW-1:0];
      ib          = (ia == AW'(DELAY_DEPTH - 1)) ? '0 : ia + 1'b1;
      carrier_mag = carrier_ff[SAMPLE_W-1] ? -carrier_ff : carrier_ff;
      gate        = carrier_mag < SAMPLE_W'(GATE_LSB);
      mod_ext     = {{(MUL_A_W-MOD_W){mod_ff[MOD_W-1]}}, mod_ff};
      off         = round_shift(mul_p, FRAC_B);
      ip_new      = IP_W'(wi_ff) - IP_W'(BASE_OFFSET) + off[16+IP_W-1:16];
      interp_sum  = mul_p + ($signed({{(MUL_P_W-SAMPLE_W-16){sa_ff[SAMPLE_W-1]}},
                                      sa_ff, 16'b0}));
      mix_sum     = mul_p + ($signed({{(MUL_P_W-SAMPLE_W-16){carrier_ff[SAMPLE_W-1]}},
                                      carrier_ff, 16'b0}));
      ramp_start  = depth_target_ff != depth_goal_ff;
      ramp_now    = ramp_start && (ramp_steps_ff == 16'd0);
      out_free    = !rsp_valid_ff || rsp_ready;
   end

   // ------------------------------------------------------------ multiplier operands
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      in_mul = 1'b1;
      unique case (state_ff)
         ST_MUL_C: begin
            mul_a = {{(MUL_A_W-SAMPLE_W){cin_ff[SAMPLE_W-1]}}, cin_ff};
            mul_b = MUL_B_W'(carrier_gain_ff);
         end
         ST_MUL_M: begin
            mul_a = {{(MUL_A_W-SAMPLE_W){min_ff[SAMPLE_W-1]}}, min_ff};
            mul_b = MUL_B_W'(modulator_gain_ff);
         end
         ST_MUL_O: begin
            mul_a = mod_ext;
            mul_b = depth_current_ff[DEPTH_W-1:DEPTH_W-MUL_B_W];
         end
         ST_MUL_I: begin
            mul_a = {{(MUL_A_W-SAMPLE_W){sb_ff[SAMPLE_W-1]}}, sb_ff}
                    - {{(MUL_A_W-SAMPLE_W){sa_ff[SAMPLE_W-1]}}, sa_ff};
            mul_b = MUL_B_W'(frac_ff);
         end
         ST_MUL_R: begin
            mul_a = carrier_ff[SAMPLE_W-1] ? -mod_ext : mod_ext;
            mul_b = MUL_B_W'(carrier_mag);
         end
         ST_MUL_X: begin
            mul_a = wet_ff - {{(MUL_A_W-SAMPLE_W){carrier_ff[SAMPLE_W-1]}}, carrier_ff};
            mul_b = MUL_B_W'(w_eff);
         end
         default: in_mul = 1'b0;
      endcase
   end

   assign mul_start = in_mul && !issued_ff;

   dlpm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign ram_we    = state_ff == ST_WR;
   assign ram_raddr = (state_ff == ST_RD_B) ? ib : ia;

   dlpm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (wi_ff),
      .wdata (carrier_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      rsp_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_RAMP;
         ST_RAMP:  state_in = (ramp_start && !ramp_now) ? ST_DIV : ST_ADV;
         ST_DIV:   if (div_cnt_ff == DIV_CNT_W'(DEPTH_W - 1)) state_in = ST_QUOT;
         ST_QUOT:  state_in = ST_ADV;
         ST_ADV:   state_in = ST_MUL_C;
         ST_MUL_C: if (mul_done) state_in = ST_WR;
         ST_WR:    state_in = ST_MUL_M;
         ST_MUL_M: if (mul_done) state_in = mode_select_ff ? ST_MUL_R : ST_MUL_O;
         ST_MUL_O: if (mul_done) state_in = ST_WRAP;
         ST_WRAP: begin
            if (!ip_ff[IP_W-1] && (ip_ff < $signed(IP_W'(DELAY_DEPTH)))) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_RD_W;
         ST_RD_W:  state_in = ST_MUL_I;
         ST_MUL_I: if (mul_done) state_in = ST_MUL_X;
         ST_MUL_R: if (mul_done) state_in = ST_MUL_X;
         ST_MUL_X: begin
            // hold the finished sample until the output register frees up
            if (issued_ff && (mul_done || mix_done_ff) && out_free) begin
               rsp_go   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         carrier_gain_ff   <= 16'd16384;
         modulator_gain_ff <= 16'd4096;
         wet_amount_ff     <= 17'd32768;
         depth_target_ff   <= GOAL_W'(12800);
         mode_select_ff    <= 1'b0;
         ramp_steps_ff     <= 16'd960;
         depth_goal_ff     <= '0;
         depth_current_ff  <= '0;
         depth_step_ff     <= '0;
         ramp_remaining_ff <= '0;
         wi_ff             <= '0;
         full_ff           <= 1'b0;
         issued_ff         <= 1'b0;
         mix_done_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_CARRIER_GAIN:   carrier_gain_ff   <= csr_wdata[15:0];
               CSR_MODULATOR_GAIN: modulator_gain_ff <= csr_wdata[15:0];
               CSR_WET_AMOUNT:     wet_amount_ff     <= csr_wdata[16:0];
               CSR_DEPTH_TARGET:   depth_target_ff   <= csr_wdata[GOAL_W-1:0];
               CSR_MODE_SELECT:    mode_select_ff    <= csr_wdata[0];
               CSR_RAMP_STEPS:     ramp_steps_ff     <= csr_wdata[15:0];
               default: ;
            endcase
         end

         if (mul_start) begin
            issued_ff <= 1'b1;
         end else if (mul_done && state_ff != ST_MUL_X) begin
            issued_ff <= 1'b0;
         end else if (rsp_go) begin
            issued_ff <= 1'b0;
         end

         // remember the finished mix while the output is stalled
         if (rsp_go) begin
            mix_done_ff <= 1'b0;
         end else if (state_ff == ST_MUL_X && mul_done) begin
            mix_done_ff <= 1'b1;
         end

         if (state_ff == ST_RAMP && ramp_start) begin
            depth_goal_ff <= depth_target_ff;
            if (ramp_now) begin
               depth_current_ff  <= {depth_target_ff, {DEPTH_SHIFT{1'b0}}};
               ramp_remaining_ff <= '0;
            end else begin
               ramp_remaining_ff <= ramp_steps_ff;
            end
         end

         if (state_ff == ST_QUOT) begin
            depth_step_ff <= div_neg_ff ? -$signed(quot) : $signed(quot);
         end

         if (state_ff == ST_ADV && ramp_remaining_ff != 16'd0) begin
            ramp_remaining_ff <= ramp_remaining_ff - 1'b1;
            if (ramp_remaining_ff != 16'd1) begin
               depth_current_ff <= adv_sum[DEPTH_W-1:0];
            end else begin
               depth_current_ff <= {depth_goal_ff, {DEPTH_SHIFT{1'b0}}};
            end
         end

         if (rsp_go) begin
            rsp_valid_ff <= 1'b1;
            wi_ff        <= (wi_ff == AW'(DELAY_DEPTH - 1)) ? '0 : wi_ff + 1'b1;
            if (wi_ff == AW'(DELAY_DEPTH - 1)) begin
               full_ff <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cin_ff <= req_carrier_sample;
         min_ff <= req_modulator_sample;
      end
      if (state_ff == ST_RAMP) begin
         div_neg_ff <= num[DEPTH_W+1];
         dvd_ff     <= num_mag[DEPTH_W-1:0];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff     <= div_ge ? div_diff[15:0] : div_trial[15:0];
         dvd_ff     <= {dvd_ff[DEPTH_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (mul_done) begin
         unique case (state_ff)
            ST_MUL_C: carrier_ff <= saturate(round_shift(mul_p, 14));
            ST_MUL_M: begin
               mod_ff <= MOD_W'(round_shift(mul_p, 12));
            end
            ST_MUL_O: begin
               ip_ff   <= ip_new;
               frac_ff <= off[15:0];
            end
            ST_MUL_I: wet_ff <= gate ? '0 : WET_W'(round_shift(interp_sum, 16));
            ST_MUL_R: wet_ff <= WET_W'(round_shift(mul_p, FRAC_B - 1));
            default: ;
         endcase
      end
      if (state_ff == ST_WRAP) begin
         if (ip_ff[IP_W-1]) begin
            ip_ff <= ip_ff + IP_W'(DELAY_DEPTH);
         end else if (ip_ff >= $signed(IP_W'(DELAY_DEPTH))) begin
            ip_ff <= ip_ff - IP_W'(DELAY_DEPTH);
         end
      end
      // entries past the fill mark were never written and read as zero
      if (state_ff == ST_RD_A) begin
         rvalid_ff <= full_ff || (ia <= wi_ff);
      end
      if (state_ff == ST_RD_B) begin
         sa_ff     <= rvalid_ff ? $signed(ram_rdata) : '0;
         rvalid_ff <= full_ff || (ib <= wi_ff);
      end
      if (state_ff == ST_RD_W) begin
         sb_ff <= rvalid_ff ? $signed(ram_rdata) : '0;
      end
      if (rsp_go) begin
         rsp_data_ff <= saturate(round_shift(mix_sum, 16));
      end
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_data_ff;

   // ------------------------------------------------------------ checks
   a_wrap_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_A |-> !ip_ff[IP_W-1] && ip_ff < $signed(IP_W'(DELAY_DEPTH)))
      else $error("read position outside the delay line");

   a_ramp_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV && ramp_remaining_ff == 16'd1)
      |=> depth_current_ff == {depth_goal_ff, {DEPTH_SHIFT{1'b0}}})
      else $error("depth ramp did not land on its goal");

   a_full_sticks: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("fill mark dropped");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !issued_ff && !mul_done)
      else $error("multiplier busy while idle");

endmodule

// ----- hw/rtl/dlpm_ram.sv -----
module dlpm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/dlpm_mul.sv -----
module dlpm_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [dlpm_pkg::MUL_A_W-1:0]  a,
   input  logic        [dlpm_pkg::MUL_B_W-1:0]  b,
   output logic                                 done,
   output logic signed [dlpm_pkg::MUL_P_W-1:0]  product
);
   import dlpm_pkg::*;

   logic signed [MUL_A_W-1:0] a_ff;
   logic signed [MUL_H_W-1:0] hi_ff;
   logic        [MUL_B_W-1:0] lo_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic signed [MUL_H_W-1:0] sum;

   always_comb begin
      sum = hi_ff;
      if (lo_ff[0]) begin
         sum = hi_ff + $signed({{(MUL_H_W-MUL_A_W){a_ff[MUL_A_W-1]}}, a_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // partial product shifts right one bit per cycle as multiplier bits retire
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= sum >>> 1;
         lo_ff <= {sum[0], lo_ff[MUL_B_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = $signed({hi_ff, lo_ff});

endmodule

// ----- verif/tb_delay_line_phase_mod_ring_mod_mixer_core.sv -----
module tb_delay_line_phase_mod_ring_mod_mixer_core;
   import dlpm_pkg::*;

   localparam int LINE_LEN    = 4096;
   localparam int LINE_OFFSET = 1024;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_ITEMS = 210;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_carrier_sample = '0;
   logic signed [SAMPLE_W-1:0] req_modulator_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mixed_sample;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   delay_line_phase_mod_ring_mod_mixer_core dut (.*);

   always #4 clock = ~clock;

   // mixer model state and register copies
   logic signed [SAMPLE_W-1:0] line_mem [LINE_LEN];
   int unsigned     wr_pos;
   longint unsigned depth_now;
   longint          depth_inc;
   int unsigned     ramp_left;
   longint unsigned goal_now;
   longint unsigned gain_car, gain_mod, wet_frac, depth_goal_reg, ramp_len;
   bit              ring_mode;

   logic signed [SAMPLE_W-1:0] mix_expected [$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   function automatic longint mul_rnd(longint a, longint b, int s);
      logic [127:0] ua, ub, pr;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      pr = (ua * ub + (128'd1 << (s - 1))) >> s;
      return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
   endfunction

   function automatic longint shift_rnd(longint v, int s);
      longint m;
      m = (((v < 0) ? -v : v) + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic void model_reset();
      gain_car = 16384; gain_mod = 4096; wet_frac = 32768;
      depth_goal_reg = 12800; ring_mode = 0; ramp_len = 960;
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_pos = 0; depth_now = 0; depth_inc = 0; ramp_left = 0; goal_now = 0;
   endfunction

   function automatic void model_write(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_CARRIER_GAIN:   gain_car = d[15:0];
         CSR_MODULATOR_GAIN: gain_mod = d[15:0];
         CSR_WET_AMOUNT:     wet_frac = d[16:0];
         CSR_DEPTH_TARGET:   depth_goal_reg = d[17:0];
         CSR_MODE_SELECT:    ring_mode = d[0];
         CSR_RAMP_STEPS:     ramp_len = d[15:0];
         default: ;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] mix_sample(longint cin, longint min);
      longint car, mdl, wet, w, off, pos, ia, ib, f;
      w = (wet_frac > 65536) ? 65536 : longint'(wet_frac);
      if (depth_goal_reg != goal_now) begin
         goal_now = depth_goal_reg;
         if (ramp_len == 0) begin
            depth_now = goal_now << DEPTH_SHIFT;
            ramp_left = 0;
         end else begin
            ramp_left = ramp_len;
            depth_inc = (longint'(goal_now << DEPTH_SHIFT) - longint'(depth_now))
                        / longint'(ramp_len);
         end
      end
      if (ramp_left > 0) begin
         ramp_left--;
         if (ramp_left > 0) depth_now = longint'(depth_now) + depth_inc;
         else depth_now = goal_now << DEPTH_SHIFT;
      end
      car = clip24(mul_rnd(cin, longint'(gain_car), 14));
      line_mem[wr_pos] = car[SAMPLE_W-1:0];
      mdl = mul_rnd(min, longint'(gain_mod), 12);
      if (!ring_mode) begin
         off = mul_rnd(longint'(depth_now >> 14), mdl, FRAC_B);
         pos = (longint'(wr_pos) - LINE_OFFSET) * 65536 + off;
         pos = pos % (longint'(LINE_LEN) * 65536);
         if (pos < 0) pos += longint'(LINE_LEN) * 65536;
         ia = pos >>> 16;
         f = pos & 64'hFFFF;
         ib = (ia + 1 >= LINE_LEN) ? 0 : ia + 1;
         wet = shift_rnd(longint'(line_mem[ia]) * (65536 - f)
                         + longint'(line_mem[ib]) * f, 16);
         // gate near-silent carrier
         if (((car < 0) ? -car : car) < GATE_LSB) wet = 0;
      end else begin
         wet = mul_rnd(car, mdl, FRAC_B - 1);
      end
      wr_pos = (wr_pos + 1) % LINE_LEN;
      return SAMPLE_W'(clip24(shift_rnd(car * (65536 - w) + wet * w, 16)));
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (mix_expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected mixed sample %0d", rsp_mixed_sample);
         end else begin
            logic signed [SAMPLE_W-1:0] want;
            want = mix_expected.pop_front();
            if (rsp_mixed_sample !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mixed_sample mismatch: expected %0d actual %0d",
                           want, rsp_mixed_sample);
            end
         end
      end
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (mix_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      model_write(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pair(logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] m,
                            bit known, logic signed [SAMPLE_W-1:0] want);
      logic signed [SAMPLE_W-1:0] pred;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_carrier_sample <= c;
      req_modulator_sample <= m;
      do @(posedge clock); while (!req_ready);
      // transfer done at this edge
      pred = mix_sample(c, m);
      mix_expected.push_back(known ? want : pred);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_reg(int lo, int hi);
      case ($urandom_range(9))
         0: return CSR_DATA_W'(lo);
         1: return CSR_DATA_W'(hi);
         2: return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
         1: return $signed(24'($urandom_range(24))) - 24'sd12;
         2: return $signed(24'($urandom_range(4000))) - 24'sd2000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   typedef struct {
      bit                         is_reg;
      csr_index_type              idx;
      logic [CSR_DATA_W-1:0]      data;
      logic signed [SAMPLE_W-1:0] car;
      logic signed [SAMPLE_W-1:0] mdl;
      bit                         known;
      logic signed [SAMPLE_W-1:0] want;
   } step_row_type;

   step_row_type plan [] = '{
      '{0, CSR_CARRIER_GAIN, 0, 0, 0, 1, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8388607, 0, 1, 4194304},
      '{0, CSR_CARRIER_GAIN, 0, -8388608, 0, 1, -4194304},
      '{0, CSR_CARRIER_GAIN, 0, 7, 8388607, 1, 4},
      '{0, CSR_CARRIER_GAIN, 0, -7, -8388608, 1, -4},
      '{0, CSR_CARRIER_GAIN, 0, 1000000, 8388607, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, -1000000, -8388608, 0, 0},
      '{1, CSR_WET_AMOUNT, 65536, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8, 0, 0, 0},
      '{1, CSR_CARRIER_GAIN, 32768, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8388607, 0, 1, 0},
      '{1, CSR_MODE_SELECT, 1, 0, 0, 0, 0},
      '{1, CSR_MODULATOR_GAIN, 49152, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8388607, 8388607, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, -8388608, 8388607, 0, 0},
      '{1, CSR_WET_AMOUNT, 131071, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 4194304, -4194304, 0, 0},
      '{1, CSR_MODE_SELECT, 2, 0, 0, 0, 0},
      '{1, CSR_RAMP_STEPS, 0, 0, 0, 0, 0},
      '{1, CSR_DEPTH_TARGET, 262143, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8388607, 8388607, 0, 0},
      '{1, CSR_CARRIER_GAIN, 0, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, 8388607, -1, 1, 0},
      '{1, CSR_WET_AMOUNT, 0, 0, 0, 0, 0},
      '{0, CSR_CARRIER_GAIN, 0, -8388608, 5, 0, 0}
   };

   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].data);
         else send_pair(plan[i].car, plan[i].mdl, plan[i].known, plan[i].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 29) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 29) : 0;
         write_reg(CSR_CARRIER_GAIN, pick_reg(0, 32768));
         write_reg(CSR_MODULATOR_GAIN, pick_reg(0, 49152));
         write_reg(CSR_WET_AMOUNT, pick_reg(0, 65536));
         write_reg(CSR_MODE_SELECT, CSR_DATA_W'($urandom_range(3)));
         write_reg(CSR_RAMP_STEPS, $urandom_range(3) == 0 ? pick_reg(1, 65535)
                                                          : CSR_DATA_W'($urandom_range(64)));
         write_reg(CSR_DEPTH_TARGET, pick_reg(0, 256000));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // retarget depth now and then so ramps restart mid-stream
            if (n % 50 == 49) write_reg(CSR_DEPTH_TARGET, pick_reg(0, 256000));
            if (ph == 0 && n == 100) wait_drained();
            send_pair(pick_sample(), pick_sample(), 0, '0);
         end
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dlpm_pkg.sv
hw/rtl/dlpm_ram.sv
hw/rtl/dlpm_mul.sv
hw/rtl/delay_line_phase_mod_ring_mod_mixer_core.sv
verif/tb_delay_line_phase_mod_ring_mod_mixer_core.sv
